[hw/rtl/snsd_pkg.sv]
// Shared types, constants, segment tables and microcode for the segment display writer.
package snsd_pkg;

  localparam int MAX_DIGITS_DEF  = 6;
  localparam int CLEAR_FIRST_DEF = 2;
  localparam int CLEAR_END_DEF   = 20;

  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 8;
  localparam int VALUE_W    = 32;
  localparam int NUM_SLOTS  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int BCD_DIGITS = 6;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  // 999999 fits in 20 bits: enough for any displayable magnitude
  localparam int BIN_W      = 20;
  localparam int DIGIT_IDX_W = $clog2(BCD_DIGITS);

  localparam logic [DATA_W-1:0] SIGN_BITS  = 8'h04;
  localparam logic [DATA_W-1:0] CLEAR_BYTE = 8'h00;
  localparam logic [2:0]        INF_LAST   = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT6 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd6;

  typedef logic [NUM_SLOTS-1:0][ADDR_W-1:0] slot_arr_t;

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } bcd_res_t;

  typedef enum logic [2:0] {
    UPC_WAIT, UPC_CLEAR, UPC_SIGN, UPC_DECIDE, UPC_DIGIT, UPC_INF
  } upc_t;

  typedef enum logic [2:0] {
    OP_WAIT, OP_CLEAR, OP_SIGN, OP_DECIDE, OP_DIGIT, OP_INF
  } op_t;

  typedef struct packed {
    op_t  op;
    upc_t nxt;
    upc_t jmp;
  } uword_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    case (pc)
      UPC_WAIT:   w = '{op: OP_WAIT,   nxt: UPC_CLEAR,  jmp: UPC_WAIT};
      UPC_CLEAR:  w = '{op: OP_CLEAR,  nxt: UPC_SIGN,   jmp: UPC_WAIT};
      UPC_SIGN:   w = '{op: OP_SIGN,   nxt: UPC_DECIDE, jmp: UPC_WAIT};
      UPC_DECIDE: w = '{op: OP_DECIDE, nxt: UPC_DIGIT,  jmp: UPC_INF};
      UPC_DIGIT:  w = '{op: OP_DIGIT,  nxt: UPC_WAIT,   jmp: UPC_WAIT};
      UPC_INF:    w = '{op: OP_INF,    nxt: UPC_WAIT,   jmp: UPC_WAIT};
      default:    w = '{op: OP_WAIT,   nxt: UPC_WAIT,   jmp: UPC_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_reset(logic [CFG_IDX_W-1:0] idx);
    logic [ADDR_W-1:0] a;
    case (idx)
      REG_SLOT1: a = 5'd4;
      REG_SLOT2: a = 5'd6;
      REG_SLOT3: a = 5'd8;
      REG_SLOT4: a = 5'd10;
      REG_SLOT5: a = 5'd2;
      REG_SLOT6: a = 5'd18;
      default:   a = 5'd0;
    endcase
    return a;
  endfunction

  function automatic logic [DATA_W-1:0] seg_digit(logic [3:0] d);
    logic [DATA_W-1:0] s;
    case (d)
      4'd0:    s = 8'hFC;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hDB;
      4'd3:    s = 8'hF3;
      4'd4:    s = 8'h67;
      4'd5:    s = 8'hB7;
      4'd6:    s = 8'hBF;
      4'd7:    s = 8'hE4;
      4'd8:    s = 8'hFF;
      4'd9:    s = 8'hF7;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // I, N, F as two bytes each, in write order
  function automatic logic [DATA_W-1:0] inf_byte(logic [2:0] k);
    logic [DATA_W-1:0] s;
    case (k)
      3'd0:    s = 8'h90;
      3'd1:    s = 8'h50;
      3'd2:    s = 8'h6C;
      3'd3:    s = 8'h82;
      3'd4:    s = 8'h8F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/signed_number_segment_display_writer.sv]
// Top level of the signed number segment display writer.
// The first write beat passes the step counter and the output register after a value is accepted.
// One value at a time; the clear run and the sign step overlap the serial BCD conversion.
// Reset: synchronous, active high; slot addresses return to 4, 6, 8, 10, 2, 18.
module signed_number_segment_display_writer
  import snsd_pkg::*;
#(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int CLEAR_FIRST = CLEAR_FIRST_DEF,
  parameter int CLEAR_END   = CLEAR_END_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [ADDR_W-1:0]         cfg_data,
  // value channel
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic signed [VALUE_W-1:0] value,
  // display memory write channel
  output logic                      wr_valid,
  input  logic                      wr_stall,
  output logic [ADDR_W-1:0]         mem_address,
  output logic [DATA_W-1:0]         mem_data,
  output logic                      last_write
);

  slot_arr_t slot;

  // Writes always land: the user must change configuration only while idle; the block does not enforce it
  assign cfg_ready = 1'b1;

  // Slot address registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot[i] <= slot_reset(CFG_IDX_W'(i));
      end
    end else if (cfg_valid && cfg_ready && cfg_index < REG_COUNT) begin
      slot[cfg_index] <= cfg_data;
    end
  end

  // Sequencer runs the write program: clears, sign, then digits or INF
  snsd_sequencer #(
    .MAX_DIGITS  (MAX_DIGITS),
    .CLEAR_FIRST (CLEAR_FIRST),
    .CLEAR_END   (CLEAR_END)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .slot        (slot),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .value       (value),
    .wr_valid    (wr_valid),
    .wr_stall    (wr_stall),
    .mem_address (mem_address),
    .mem_data    (mem_data),
    .last_write  (last_write)
  );

`ifndef SYNTH
  // One value at a time: after an accepted beat the input side must close
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("value accepted while previous sequence still running");

  // When ready for a new value, only the closing beat may still wait
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    !item_stall && wr_valid |-> last_write)
    else $error("idle with a non-final write still pending");

  // A non-final beat taken means more of the sequence follows: either the
  // program is still running or the closing beat was loaded on that edge
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    wr_valid && !wr_stall && !last_write |=> item_stall || wr_valid)
    else $error("sequence ended without a final write");
`endif

endmodule

[hw/rtl/snsd_dabble.sv]
// Bit-serial shift-and-add-3 binary to BCD converter.
module snsd_dabble
  import snsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [BIN_W-1:0] bin_in,
  output bcd_res_t         res
);

  localparam int CNT_W = $clog2(BIN_W + 1);

  logic [BIN_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= bin_in;
      bcd <= '0;
      cnt <= CNT_W'(BIN_W);
    end else if (busy) begin
      bcd <= {adj[BCD_W-2:0], bin[BIN_W-1]};
      bin <= {bin[BIN_W-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign res.done = !busy;
  assign res.bcd  = bcd;

endmodule

[hw/rtl/snsd_sequencer.sv]
// Microcoded sequencer: step counter, control ROM, datapath and output register.
module snsd_sequencer
  import snsd_pkg::*;
#(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int CLEAR_FIRST = CLEAR_FIRST_DEF,
  parameter int CLEAR_END   = CLEAR_END_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  slot_arr_t                 slot,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      wr_valid,
  input  logic                      wr_stall,
  output logic [ADDR_W-1:0]         mem_address,
  output logic [DATA_W-1:0]         mem_data,
  output logic                      last_write
);

  localparam logic [VALUE_W-1:0] LIMIT     = VALUE_W'(10 ** MAX_DIGITS);
  localparam logic [ADDR_W-1:0]  CLR_FIRST = ADDR_W'(CLEAR_FIRST);
  localparam logic [ADDR_W-1:0]  CLR_END   = ADDR_W'(CLEAR_END);
  localparam logic [ADDR_W-1:0]  CLR_LAST  = ADDR_W'(CLEAR_END - 1);

  upc_t               pc, pc_next;
  uword_t             uw;
  logic [ADDR_W-1:0]  cnt, cnt_next;
  logic [VALUE_W-1:0] mag, mag_next;
  logic               neg, neg_next;
  logic [BCD_W-1:0]   dig, dig_next;
  logic [DIGIT_IDX_W-1:0] lenm1;
  logic               accept;
  logic               can_emit;
  logic               emit;
  logic [ADDR_W-1:0]  e_addr;
  logic [DATA_W-1:0]  e_data;
  logic               e_last;
  bcd_res_t           res;

  snsd_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .bin_in (mag_next[BIN_W-1:0]),
    .res    (res)
  );

  // Index of the highest nonzero digit; zero still shows one digit
  always_comb begin
    lenm1 = '0;
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (res.bcd[4*i +: 4] != 4'd0) begin
        lenm1 = DIGIT_IDX_W'(i);
      end
    end
  end

  assign uw         = ucode(pc);
  assign can_emit   = !wr_valid || !wr_stall;
  assign item_stall = (uw.op != OP_WAIT);

  always_comb begin
    pc_next  = pc;
    cnt_next = cnt;
    mag_next = mag;
    neg_next = neg;
    dig_next = dig;
    accept   = 1'b0;
    emit     = 1'b0;
    e_addr   = '0;
    e_data   = CLEAR_BYTE;
    e_last   = 1'b0;
    case (uw.op)
      OP_WAIT: begin
        if (item_valid) begin
          accept   = 1'b1;
          neg_next = value[VALUE_W-1];
          mag_next = value[VALUE_W-1] ? (~$unsigned(value)) + VALUE_W'(1) : $unsigned(value);
          cnt_next = CLR_FIRST;
          pc_next  = uw.nxt;
        end
      end
      OP_CLEAR: begin
        if (cnt < CLR_END) begin
          emit   = 1'b1;
          e_addr = cnt;
          if (can_emit) begin
            cnt_next = cnt + ADDR_W'(1);
            if (cnt >= CLR_LAST) begin
              pc_next = uw.nxt;
            end
          end
        end else begin
          pc_next = uw.nxt;
        end
      end
      OP_SIGN: begin
        if (neg) begin
          emit   = 1'b1;
          e_addr = slot[REG_SLOT1] + ADDR_W'(1);
          e_data = SIGN_BITS;
          if (can_emit) begin
            pc_next = uw.nxt;
          end
        end else begin
          pc_next = uw.nxt;
        end
      end
      OP_DECIDE: begin
        if (res.done) begin
          dig_next = res.bcd;
          if (mag >= LIMIT) begin
            cnt_next = '0;
            pc_next  = uw.jmp;
          end else begin
            cnt_next = ADDR_W'(lenm1);
            pc_next  = uw.nxt;
          end
        end
      end
      OP_DIGIT: begin
        emit   = 1'b1;
        e_addr = slot[cnt[DIGIT_IDX_W-1:0]];
        e_data = seg_digit(dig[3:0]);
        e_last = (cnt == '0);
        if (can_emit) begin
          dig_next = {4'd0, dig[BCD_W-1:4]};
          if (cnt == '0) begin
            pc_next = uw.nxt;
          end else begin
            cnt_next = cnt - ADDR_W'(1);
          end
        end
      end
      OP_INF: begin
        emit   = 1'b1;
        e_addr = slot[{1'b0, cnt[2:1]}] + ADDR_W'(cnt[0]);
        e_data = inf_byte(cnt[2:0]);
        e_last = (cnt[2:0] == INF_LAST);
        if (can_emit) begin
          if (cnt[2:0] == INF_LAST) begin
            pc_next = uw.nxt;
          end else begin
            cnt_next = cnt + ADDR_W'(1);
          end
        end
      end
      default: begin
        pc_next = UPC_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= UPC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    mag <= mag_next;
    neg <= neg_next;
    dig <= dig_next;
  end

  // Output register: hold a beat until taken, refill in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (emit && can_emit) begin
      wr_valid <= 1'b1;
    end else if (!wr_stall) begin
      wr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && can_emit) begin
      mem_address <= e_addr;
      mem_data    <= e_data;
      last_write  <= e_last;
    end
  end

endmodule

[tb/signed_number_segment_display_writer_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the signed number segment display writer.
module signed_number_segment_display_writer_test;
  import snsd_pkg::*;

  // Seven-segment patterns, digit 0 in the low byte.
  localparam logic [9:0][DATA_W-1:0] DIGIT_SEGS = {
    8'hF7, 8'hFF, 8'hE4, 8'hBF, 8'hB7, 8'h67, 8'hF3, 8'hDB, 8'h60, 8'hFC
  };
  // I, N, F as two bytes each, first byte of I in the low byte.
  localparam logic [5:0][DATA_W-1:0] INF_SEGS = {
    8'h00, 8'h8F, 8'h82, 8'h6C, 8'h50, 8'h90
  };
  localparam slot_arr_t RESET_SLOTS = {5'd18, 5'd2, 5'd10, 5'd8, 5'd6, 5'd4};

  localparam int QUIET_LIMIT  = 3000;  // cycles with no beat on any channel
  localparam int PRESS_CYCLES = 400;   // length of the forced write-side hold-off
  localparam int BATCH_ITEMS  = 55;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } mem_write_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [ADDR_W-1:0]         cfg_data = '0;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      wr_valid;
  logic                      wr_stall = 1'b0;
  logic [ADDR_W-1:0]         mem_address;
  logic [DATA_W-1:0]         mem_data;
  logic                      last_write;

  signed_number_segment_display_writer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .wr_valid   (wr_valid),
    .wr_stall   (wr_stall),
    .mem_address(mem_address),
    .mem_data   (mem_data),
    .last_write (last_write)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Values waiting for the driver, and display writes the block still owes us.
  logic [VALUE_W-1:0] values_to_send[$];
  mem_write_t         expected_writes[$];
  slot_arr_t          slot_map;        // our copy of the slot address registers
  int                 values_queued = 0;
  int                 values_accepted = 0;
  int                 writes_seen = 0;
  int                 mismatches = 0;
  logic               item_beat = 1'b0;

  // Knobs set by the sequence below.
  bit                 sender_idle_en = 1'b1;
  bit                 receiver_idle_en = 1'b1;
  bit                 press_req = 1'b0;

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Work out the full write sequence for one value under the current slot map.
  function automatic void predict_display_writes(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] rest;
    int                 ndig;
    int                 i;
    mem_write_t         w;
    mem_write_t         seq[$];
    w = '0;
    // The most negative value negates to itself, which reads as 2^31 unsigned.
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;

    // Clear run over the whole digit area.
    for (i = CLEAR_FIRST_DEF; i < CLEAR_END_DEF; i++) begin
      w.addr = ADDR_W'(i);
      w.data = CLEAR_BYTE;
      seq.push_back(w);
    end

    // Sign goes one byte past slot 1, wrapping within the address field.
    if (v[VALUE_W-1]) begin
      w.addr = slot_map[0] + 5'd1;
      w.data = SIGN_BITS;
      seq.push_back(w);
    end

    ndig = 1;
    rest = mag / 10;
    while (rest != 0) begin
      ndig++;
      rest = rest / 10;
    end

    if (ndig > MAX_DIGITS_DEF) begin
      // Too wide for the display: spell INF over slots 1..3.
      for (i = 0; i < 3; i++) begin
        w.addr = slot_map[i];
        w.data = INF_SEGS[2 * i];
        seq.push_back(w);
        w.addr = slot_map[i] + 5'd1;
        w.data = INF_SEGS[2 * i + 1];
        seq.push_back(w);
      end
    end else begin
      // Units digit first, into the slot numbered by the digit count.
      rest = mag;
      for (i = ndig; i > 0; i--) begin
        w.addr = slot_map[i - 1];
        w.data = DIGIT_SEGS[rest % 10];
        seq.push_back(w);
        rest = rest / 10;
      end
    end

    for (i = 0; i < seq.size(); i++) begin
      w = seq[i];
      w.last = (i == seq.size() - 1);
      expected_writes.push_back(w);
    end
  endfunction

  // Value driver: advance on the falling edge once the previous beat went through.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else if (!item_valid || item_beat) begin
      if (send_gap > 0) begin
        item_valid <= 1'b0;
        send_gap--;
      end else if (values_to_send.size() > 0) begin
        value      <= values_to_send.pop_front();
        item_valid <= 1'b1;
        send_gap = sender_idle_en ? pick_gap() : 0;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Write-side stall: random holds, plus one long forced hold-off so the block backs up.
  int  hold_left = 0;
  int  press_count = 0;
  bit  press_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      wr_stall <= 1'b0;
      hold_left = 0;
      press_count = 0;
      press_done = 1'b0;
    end else if (press_req && !press_done) begin
      wr_stall <= 1'b1;
      press_count++;
      if (press_count >= PRESS_CYCLES) press_done = 1'b1;
    end else if (hold_left > 0) begin
      wr_stall <= 1'b1;
      hold_left--;
    end else begin
      wr_stall <= 1'b0;
      hold_left = receiver_idle_en ? pick_gap() : 0;
    end
  end

  // Monitor: sample every channel on the rising edge.
  always @(posedge clk) begin
    mem_write_t w;
    logic       bad;
    if (rst) begin
      slot_map  <= RESET_SLOTS;
      item_beat <= 1'b0;
    end else begin
      item_beat <= item_valid && !item_stall;

      if (cfg_valid && cfg_ready && cfg_index < REG_COUNT) begin
        slot_map[cfg_index] <= cfg_data;
      end

      // Check the write beat against the oldest expectation.
      if (wr_valid && !wr_stall) begin
        writes_seen++;
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: unexpected write beat %0d: addr %0d data %02h last %0b",
                     $realtime, writes_seen, mem_address, mem_data, last_write);
          end
        end else begin
          w = expected_writes.pop_front();
          bad = (mem_address !== w.addr) || (mem_data !== w.data) || (last_write !== w.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display({"%0t: write beat %0d: expected addr %0d data %02h last %0b,",
                        " got addr %0d data %02h last %0b"},
                       $realtime, writes_seen, w.addr, w.data, w.last,
                       mem_address, mem_data, last_write);
            end
          end
        end
      end

      // Predict after the check so this beat's sequence lands behind older ones.
      if (item_valid && !item_stall) begin
        predict_display_writes(value);
        values_accepted++;
      end
    end
  end

  // Watchdog: end the run if no channel moves a beat for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((item_valid && !item_stall) || (wr_valid && !wr_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $realtime, quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic queue_value(input logic [VALUE_W-1:0] v);
    values_to_send.push_back(v);
    values_queued++;
  endtask

  // Hold until every queued value went in and every write came out.
  task automatic wait_drained();
    @(negedge clk);
    while (values_accepted != values_queued || expected_writes.size() != 0) begin
      @(negedge clk);
    end
    // Let the block settle back to idle after its last write.
    repeat (3) @(negedge clk);
  endtask

  task automatic write_slot_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ADDR_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_slots(input slot_arr_t slots);
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      write_slot_reg(CFG_IDX_W'(i), slots[i]);
    end
  endtask

  // One batch of random values: mostly displayable magnitudes of every width,
  // some boundaries, and some full-range words that mostly end up as INF.
  task automatic run_random_batch(input int n);
    int                 k;
    int                 r;
    int                 ndig;
    int                 lo;
    int                 hi;
    logic [VALUE_W-1:0] v;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        v = $urandom;
      end else if (r == 2) begin
        case ($urandom_range(0, 7))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'd999999;
          3:       v = 32'd1000000;
          4:       v = 32'd0;
          5:       v = 32'hFFFF_FFFF;
          6:       v = -32'sd999999;
          default: v = -32'sd1000000;
        endcase
      end else begin
        ndig = $urandom_range(1, MAX_DIGITS_DEF);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        v = $urandom_range(hi, lo);
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
      queue_value(v);
    end
    wait_drained();
  endtask

  initial begin
    slot_arr_t slots;
    int        i;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero, one and two digit edges, every digit, sign, widest values, INF.
    queue_value(32'd0);
    queue_value(32'd1);
    queue_value(-32'sd1);
    queue_value(32'd9);
    queue_value(-32'sd9);
    queue_value(32'd10);
    queue_value(32'd99);
    queue_value(-32'sd100);
    queue_value(32'd12345);
    queue_value(-32'sd67890);
    queue_value(32'd123456);
    queue_value(-32'sd654321);
    queue_value(32'd999999);
    queue_value(-32'sd999999);
    queue_value(32'd1000000);
    queue_value(-32'sd1000000);
    queue_value(32'h7FFF_FFFF);
    queue_value(32'h8000_0000);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h5555_5555);
    queue_value(32'hAAAA_AAAA);
    queue_value(32'd8);
    wait_drained();

    // Every slot at address 0; indexes past the last slot must be ignored.
    write_slot_reg(REG_COUNT, 5'd31);
    write_slot_reg(REG_COUNT + 3'd1, 5'd17);
    load_slots('0);
    run_random_batch(BATCH_ITEMS);

    // Every slot at the top of the field: sign and second letter bytes wrap to 0.
    // Hold off the write side for a long stretch while values keep coming.
    load_slots('1);
    press_req = 1'b1;
    run_random_batch(BATCH_ITEMS);

    // Random in-range layout with no idling on either side.
    for (i = 0; i < NUM_SLOTS; i++) slots[i] = ADDR_W'($urandom_range(0, 18));
    load_slots(slots);
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    run_random_batch(BATCH_ITEMS);
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;

    // Random over the whole field, out-of-range addresses included.
    for (i = 0; i < NUM_SLOTS; i++) slots[i] = ADDR_W'($urandom_range(0, 31));
    load_slots(slots);
    run_random_batch(BATCH_ITEMS);

    // Back to the power-up layout.
    load_slots(RESET_SLOTS);
    run_random_batch(BATCH_ITEMS);

    // Highest in-range address on every slot.
    for (i = 0; i < NUM_SLOTS; i++) slots[i] = 5'd18;
    load_slots(slots);
    run_random_batch(BATCH_ITEMS);

    if (expected_writes.size() != 0) begin
      $display("%0d expected writes never arrived", expected_writes.size());
    end
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[signed_number_segment_display_writer.f]
hw/rtl/snsd_pkg.sv
hw/rtl/snsd_dabble.sv
hw/rtl/snsd_sequencer.sv
hw/rtl/signed_number_segment_display_writer.sv
tb/signed_number_segment_display_writer_test.sv
